/* sv/ipq_pkg.sv */
// Shared types and constants for the indexed priority queue.
// Used by ipq_ctrl, ipq_datapath and indexed_priority_queue_core.
package ipq_pkg;

    localparam int CAPACITY = 64;
    localparam int ID_W     = 6;
    localparam int CNT_W    = 7;
    localparam int PRIO_W   = 16;
    localparam int OP_W     = 3;
    localparam int ST_W     = 3;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 32;

    localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
    localparam logic [OP_W-1:0] OP_INCREASE = 3'd1;
    localparam logic [OP_W-1:0] OP_DECREASE = 3'd2;
    localparam logic [OP_W-1:0] OP_POP      = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY    = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_BAD_ID   = 3'd1;
    localparam logic [ST_W-1:0] ST_PRESENCE = 3'd2;
    localparam logic [ST_W-1:0] ST_PRIO     = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic            load;        // latch input word
        logic            rd_id;       // priority read at entry id, else at order read data
        logic            ord_next;    // order read at cursor + 1
        logic            scan_init;
        logic            scan_step;
        logic            move_init;
        logic            move_step;
        logic            fin_write;   // flush last pending order write
        logic            link;        // commit entry, flags and count
        logic            grab_pop;
        logic            grab_query;
        logic            set_status;
        logic [ST_W-1:0] status;
        logic            emit;        // load output register
    } ipq_cmd_t;

    typedef struct packed {
        logic            in_valid;
        logic [OP_W-1:0] op;
        logic            bad_id;
        logic            present;
        logic            count_zero;
        logic            scan_last;
        logic            clash;
        logic            viol;
        logic            move_none;
        logic            move_last;
        logic            out_free;
    } ipq_stat_t;

endpackage

/* sv/ipq_datapath.sv */
// Datapath: order list and priority memories, presence flags, scan and shift cursors.
// Depends on ipq_pkg; driven by commands from ipq_ctrl.
module ipq_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ipq_pkg::ipq_cmd_t                   cmd,
    output ipq_pkg::ipq_stat_t                  stat,
    input  logic                                s_tvalid,
    input  logic [ipq_pkg::S_DATA_W-1:0]        s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ipq_pkg::M_DATA_W-1:0]        m_tdata
);

    localparam int ID_W   = ipq_pkg::ID_W;
    localparam int CNT_W  = ipq_pkg::CNT_W;
    localparam int PRIO_W = ipq_pkg::PRIO_W;

    logic [PRIO_W-1:0] prio_mem  [ipq_pkg::CAPACITY];
    logic [ID_W-1:0]   order_mem [ipq_pkg::CAPACITY];

    logic [ipq_pkg::OP_W-1:0] op_reg;
    logic [ID_W-1:0]          id_reg;
    logic signed [PRIO_W-1:0] req_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [ipq_pkg::CAPACITY-1:0] present_reg;

    logic [CNT_W-1:0] k_reg, j_reg, pos_reg, idpos_reg, pend_addr_reg;
    logic             found_reg, clash_reg, up_reg, pend_valid_reg;

    logic [ID_W-1:0]          order_rd_reg;
    logic signed [PRIO_W-1:0] prio_rd_reg;

    logic [ipq_pkg::ST_W-1:0] res_status_reg;
    logic [ID_W-1:0]          res_id_reg;
    logic [PRIO_W-1:0]        res_prio_reg;

    logic                            m_tvalid_reg;
    logic [ipq_pkg::M_DATA_W-1:0]    m_tdata_reg;

    logic [CNT_W-1:0] k_inc, pos_eff, idpos_eff;
    logic [ID_W-1:0]  order_raddr, prio_raddr, order_waddr, order_wdata;
    logic             order_we;
    logic             is_self;

    assign k_inc   = k_reg + 7'd1;
    assign is_self = (order_rd_reg == id_reg);

    assign order_raddr = cmd.ord_next ? k_inc[ID_W-1:0] : k_reg[ID_W-1:0];
    assign prio_raddr  = cmd.rd_id ? id_reg : order_rd_reg;

    // pop removes the head and refills at the tail; others land after the last >= entry
    assign idpos_eff = (op_reg == ipq_pkg::OP_POP) ? '0 : idpos_reg;
    assign pos_eff   = (op_reg == ipq_pkg::OP_POP) ? count_reg - 7'd1 :
                       (found_reg ? pos_reg : j_reg);

    always_comb begin
        order_we    = 1'b0;
        order_waddr = pend_addr_reg[ID_W-1:0];
        order_wdata = order_rd_reg;
        if (cmd.link && op_reg != ipq_pkg::OP_POP) begin
            order_we    = 1'b1;
            order_waddr = pos_reg[ID_W-1:0];
            order_wdata = id_reg;
        end else if (cmd.fin_write || (cmd.move_step && pend_valid_reg)) begin
            order_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (order_we) begin
            order_mem[order_waddr] <= order_wdata;
        end
        order_rd_reg <= order_mem[order_raddr];
        if (cmd.link && op_reg != ipq_pkg::OP_POP) begin
            prio_mem[id_reg] <= req_reg;
        end
        prio_rd_reg <= prio_mem[prio_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg         <= s_tdata[2:0];
            id_reg         <= s_tdata[8:3];
            req_reg        <= s_tdata[24:9];
            res_status_reg <= ipq_pkg::ST_OK;
            res_id_reg     <= s_tdata[8:3];
            res_prio_reg   <= '0;
            k_reg          <= '0;
        end
        if (cmd.set_status) begin
            res_status_reg <= cmd.status;
        end
        if (cmd.grab_query) begin
            res_prio_reg <= prio_rd_reg;
        end
        if (cmd.grab_pop) begin
            res_id_reg   <= order_rd_reg;
            res_prio_reg <= prio_rd_reg;
        end
        if (cmd.scan_init) begin
            k_reg     <= '0;
            j_reg     <= '0;
            found_reg <= 1'b0;
            clash_reg <= 1'b0;
            idpos_reg <= count_reg;
        end
        if (cmd.scan_step) begin
            if (is_self) begin
                idpos_reg <= k_reg;
            end else begin
                if (prio_rd_reg == req_reg) begin
                    clash_reg <= 1'b1;
                end
                if (prio_rd_reg < req_reg && !found_reg) begin
                    pos_reg   <= j_reg;
                    found_reg <= 1'b1;
                end
                j_reg <= j_reg + 7'd1;
            end
            k_reg <= k_inc;
        end
        if (cmd.move_init) begin
            pos_reg        <= pos_eff;
            idpos_reg      <= idpos_eff;
            up_reg         <= (pos_eff < idpos_eff);
            k_reg          <= (pos_eff < idpos_eff) ? idpos_eff - 7'd1 : idpos_eff + 7'd1;
            pend_valid_reg <= 1'b0;
        end
        if (cmd.move_step) begin
            pend_valid_reg <= 1'b1;
            pend_addr_reg  <= up_reg ? k_reg + 7'd1 : k_reg - 7'd1;
            k_reg          <= up_reg ? k_reg - 7'd1 : k_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            present_reg <= '0;
        end else if (cmd.link) begin
            unique case (op_reg)
                ipq_pkg::OP_INSERT: begin
                    count_reg           <= count_reg + 7'd1;
                    present_reg[id_reg] <= 1'b1;
                end
                ipq_pkg::OP_POP: begin
                    count_reg               <= count_reg - 7'd1;
                    present_reg[res_id_reg] <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {count_reg, res_prio_reg, res_id_reg, res_status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        stat.in_valid   = s_tvalid;
        stat.op         = op_reg;
        stat.bad_id     = ({1'b0, id_reg} >= CNT_W'(ipq_pkg::CAPACITY));
        stat.present    = present_reg[id_reg];
        stat.count_zero = (count_reg == '0);
        stat.scan_last  = (k_inc == count_reg);
        stat.clash      = clash_reg;
        stat.viol       = (op_reg == ipq_pkg::OP_INCREASE) ? (prio_rd_reg >= req_reg)
                                                           : (prio_rd_reg <= req_reg);
        stat.move_none  = (pos_eff == idpos_eff);
        stat.move_last  = (k_reg == pos_reg);
        stat.out_free   = !m_tvalid_reg || m_tready;
    end

endmodule

/* sv/ipq_ctrl.sv */
// Controller state machine for the indexed priority queue.
// Depends on ipq_pkg; sequences ipq_datapath through command and status structs.
module ipq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  ipq_pkg::ipq_stat_t stat,
    output ipq_pkg::ipq_cmd_t  cmd,
    output logic               s_tready
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_READP  = 4'd2;
    localparam logic [3:0] S_CHECK  = 4'd3;
    localparam logic [3:0] S_QGRAB  = 4'd4;
    localparam logic [3:0] S_SCAN_A = 4'd5;
    localparam logic [3:0] S_SCAN_B = 4'd6;
    localparam logic [3:0] S_SCAN_C = 4'd7;
    localparam logic [3:0] S_MINIT  = 4'd8;
    localparam logic [3:0] S_MOVE   = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;
    localparam logic [3:0] S_LINK   = 4'd11;
    localparam logic [3:0] S_POP_A  = 4'd12;
    localparam logic [3:0] S_POP_B  = 4'd13;
    localparam logic [3:0] S_POP_C  = 4'd14;
    localparam logic [3:0] S_DONE   = 4'd15;

    logic [3:0] state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        cmd.status = ipq_pkg::ST_OK;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (stat.in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (stat.op == ipq_pkg::OP_POP) begin
                    if (stat.count_zero) begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ipq_pkg::ST_EMPTY;
                        state_next     = S_DONE;
                    end else begin
                        state_next = S_POP_A;
                    end
                end else if (stat.op > ipq_pkg::OP_QUERY) begin
                    state_next = S_DONE;
                end else if (stat.bad_id) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ipq_pkg::ST_BAD_ID;
                    state_next     = S_DONE;
                end else if (stat.op == ipq_pkg::OP_INSERT) begin
                    if (stat.present) begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ipq_pkg::ST_PRESENCE;
                        state_next     = S_DONE;
                    end else begin
                        cmd.scan_init = 1'b1;
                        state_next    = stat.count_zero ? S_MINIT : S_SCAN_A;
                    end
                end else if (!stat.present) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ipq_pkg::ST_PRESENCE;
                    state_next     = S_DONE;
                end else begin
                    state_next = S_READP;
                end
            end
            S_READP: begin
                cmd.rd_id  = 1'b1;
                state_next = (stat.op == ipq_pkg::OP_QUERY) ? S_QGRAB : S_CHECK;
            end
            S_QGRAB: begin
                cmd.grab_query = 1'b1;
                state_next     = S_DONE;
            end
            S_CHECK: begin
                if (stat.viol) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ipq_pkg::ST_PRIO;
                    state_next     = S_DONE;
                end else begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN_A;
                end
            end
            S_SCAN_A: begin
                state_next = S_SCAN_B;
            end
            S_SCAN_B: begin
                state_next = S_SCAN_C;
            end
            S_SCAN_C: begin
                // compare entry k while the order read for k+1 is in flight
                cmd.scan_step = 1'b1;
                cmd.ord_next  = 1'b1;
                state_next    = stat.scan_last ? S_MINIT : S_SCAN_B;
            end
            S_MINIT: begin
                if (stat.op == ipq_pkg::OP_INSERT && stat.clash) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ipq_pkg::ST_PRIO;
                    state_next     = S_DONE;
                end else begin
                    cmd.move_init = 1'b1;
                    state_next    = stat.move_none ? S_LINK : S_MOVE;
                end
            end
            S_MOVE: begin
                cmd.move_step = 1'b1;
                if (stat.move_last) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                cmd.fin_write = 1'b1;
                state_next    = S_LINK;
            end
            S_LINK: begin
                cmd.link   = 1'b1;
                state_next = S_DONE;
            end
            S_POP_A: begin
                state_next = S_POP_B;
            end
            S_POP_B: begin
                state_next = S_POP_C;
            end
            S_POP_C: begin
                cmd.grab_pop = 1'b1;
                state_next   = S_MINIT;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/indexed_priority_queue_core.sv */
// Indexed max-priority queue over 64 entry ids, one operation word in, one result word out.
// An unused opcode, a presence error or a pop of an empty queue goes straight to the
// result; a query or a refused priority change first reads the priority at the entry id.
// An insert scans every queued entry (an empty queue skips the scan; an equal priority
// refuses it after the scan), and an increase or decrease reads and checks the priority and
// then scans; each then shifts the entries between the old and the new place in the order
// list before it links the entry. A pop reads the head and shifts the remaining entries
// towards it. The controller walks the order list memory entry by entry (order read, then
// priority read) and moves entries one per cycle through its single write port. The
// result sits in an output register, so the next word is taken as soon as the controller
// is back at idle, even while that result still waits to be taken.
// Depends on ipq_pkg, ipq_ctrl and ipq_datapath.
module indexed_priority_queue_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ipq_pkg::S_DATA_W-1:0]  s_tdata,   // opcode, entry_id, priority_req, pad
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ipq_pkg::M_DATA_W-1:0]  m_tdata    // status, result_id, result_priority,
                                                     // queue_count
);

    ipq_pkg::ipq_cmd_t  cmd;
    ipq_pkg::ipq_stat_t stat;

    ipq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .stat     (stat),
        .cmd      (cmd),
        .s_tready (s_tready)
    );

    ipq_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
